>>> rtl/lcg_rr_pkg.sv
// Shared constants and types of the linear congruential draw engine.
`default_nettype none

package lcg_rr_pkg;

    localparam int SEED_W     = 64;
    localparam int DATA_W     = 32;
    localparam int DRAW_SHIFT = 33;
    localparam int DRAW_W     = SEED_W - DRAW_SHIFT;
    localparam int SPAN_W     = 32;

    localparam logic [SEED_W-1:0] LCG_MULT = 64'd6364136223846793005;
    localparam logic [SEED_W-1:0] LCG_INC  = 64'd1;

    // Multiplier digit width and the number of digits in one seed.
    localparam int DIGIT_W   = 4;
    localparam int MUL_STEPS = SEED_W / DIGIT_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    // The remainder unit retires one dividend bit per cycle.
    localparam int REM_STEPS = DRAW_W;
    localparam int REM_CNT_W = $clog2(REM_STEPS);

    localparam logic CMD_RAW   = 1'b0;
    localparam logic CMD_RANGE = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_REM  = 4'b0100,
        ST_DONE = 4'b1000
    } lcg_state_t;

endpackage

`default_nettype wire

>>> rtl/lcg_req_if.sv
// Request channel: command and range bounds with a valid/ready handshake.
`default_nettype none

interface lcg_req_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;

    modport source (output valid, output command, output range_low, output range_high,
                    input ready);
    modport sink   (input valid, input command, input range_low, input range_high,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/lcg_rsp_if.sv
// Result channel: drawn value and status with a valid/ready handshake.
`default_nettype none

interface lcg_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/lcg_mul.sv
// Digit-serial seed step: seed * multiplier + increment, one 4-bit digit per cycle.
`default_nettype none

module lcg_mul
    import lcg_rr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SEED_W-1:0] seed,
    output logic      [SEED_W-1:0] product,
    output logic                   done
);

    logic [SEED_W-1:0]         mcand_reg, mcand_next;
    logic [SEED_W-1:0]         mult_reg, mult_next;
    logic [SEED_W-1:0]         acc_reg, acc_next;
    logic [SEED_W+DIGIT_W-1:0] partial;
    logic [MUL_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    assign partial = mcand_reg * mult_reg[DIGIT_W-1:0];

    always_comb
    begin
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            // The increment seeds the accumulator so no extra add is needed.
            mcand_next = seed;
            mult_next  = LCG_MULT;
            acc_next   = LCG_INC;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next   = acc_reg + partial[SEED_W-1:0];
            mcand_next = mcand_reg << DIGIT_W;
            mult_next  = mult_reg >> DIGIT_W;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        acc_reg   <= acc_next;
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

`default_nettype wire

>>> rtl/lcg_rem.sv
// Bit-serial restoring remainder of the raw draw by the range span.
`default_nettype none

module lcg_rem
    import lcg_rr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DRAW_W-1:0] dividend,
    input  wire logic [SPAN_W-1:0] divisor,
    output logic      [SPAN_W-1:0] remainder,
    output logic                   done
);

    logic [DRAW_W-1:0]  dvd_reg, dvd_next;
    logic [SPAN_W-1:0]  dvs_reg, dvs_next;
    logic [SPAN_W-1:0]  rem_reg, rem_next;
    logic [SPAN_W:0]    trial;
    logic [SPAN_W:0]    diff;
    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    assign trial = {rem_reg, dvd_reg[DRAW_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits SPAN_W bits.
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[SPAN_W-1:0];
            end
            else
            begin
                rem_next = trial[SPAN_W-1:0];
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == REM_CNT_W'(REM_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

>>> rtl/lcg_random_range_core.sv
// Top level of the 64-bit linear congruential draw engine with ranged draws.
// Usage:
//   A request on req carries a command and two signed bounds. Command raw
//   returns the upper 31 bits of the advanced seed; command range returns
//   range_low + (draw mod (range_high - range_low)), or range_low with status
//   set when range_high is not above range_low. Every request advances the seed.
//   Writing cfg_wdata with cfg_we reloads the seed; write it only while idle.
// Timing:
//   One request is worked on at a time. The seed step runs on a 4-bit
//   digit-serial multiplier; a ranged draw then runs a 1-bit restoring
//   remainder. Each result is held in a result register and then moved
//   to the output register once that is free. req.ready is high only while
//   the engine is idle, so a new request is accepted only after the last
//   result has moved into the output register.
// Reset:
//   rst_n clears the seed to zero and empties the output register.
// Stalls:
//   The result waits in the output register until rsp.ready; the next request
//   is accepted meanwhile, and its result waits if the register is still full.
`default_nettype none

module lcg_random_range_core
    import lcg_rr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [SEED_W-1:0] cfg_wdata,
    lcg_req_if.sink                req,
    lcg_rsp_if.source              rsp
);

    lcg_state_t state_reg, state_next;

    logic [SEED_W-1:0]  seed_reg;
    logic               cmd_reg;
    logic [DATA_W-1:0]  lo_reg;
    logic [SPAN_W-1:0]  span_reg;
    logic               err_reg;
    logic [DATA_W-1:0]  res_value_reg, res_value_next;
    logic               res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_value_reg;
    logic               out_status_reg;

    logic               accept;
    logic               load_out;
    logic [DATA_W:0]    span_wide;
    logic               range_bad;

    logic               mul_done;
    logic [SEED_W-1:0]  product;
    logic [DRAW_W-1:0]  draw;
    logic               rem_start;
    logic               rem_done;
    logic [SPAN_W-1:0]  remainder;

    assign accept    = req.valid && req.ready;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);
    assign span_wide = {req.range_high[DATA_W-1], req.range_high}
                     - {req.range_low[DATA_W-1], req.range_low};
    assign range_bad = (req.range_high <= req.range_low);
    assign draw      = product[SEED_W-1:DRAW_SHIFT];
    assign rem_start = (state_reg == ST_MUL) && mul_done
                     && (cmd_reg == CMD_RANGE) && !err_reg;

    lcg_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .seed    (seed_reg),
        .product (product),
        .done    (mul_done)
    );

    lcg_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (draw),
        .divisor   (span_reg),
        .remainder (remainder),
        .done      (rem_done)
    );

    always_comb
    begin
        state_next      = state_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    if (cmd_reg == CMD_RAW)
                    begin
                        res_value_next  = {{(DATA_W-DRAW_W){1'b0}}, draw};
                        res_status_next = STATUS_OK;
                        state_next      = ST_DONE;
                    end
                    else if (err_reg)
                    begin
                        res_value_next  = lo_reg;
                        res_status_next = STATUS_ERR;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_REM;
                    end
                end
            end
            ST_REM:
            begin
                if (rem_done)
                begin
                    // Wraps to 32 bits; the true sum lies inside the range.
                    res_value_next  = lo_reg + remainder;
                    res_status_next = STATUS_OK;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            seed_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            else if ((state_reg == ST_MUL) && mul_done)
            begin
                seed_reg <= product;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (accept)
        begin
            cmd_reg  <= req.command;
            lo_reg   <= req.range_low;
            span_reg <= span_wide[SPAN_W-1:0];
            err_reg  <= range_bad;
        end
        if (load_out)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign req.ready  = (state_reg == ST_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.status = out_status_reg;

endmodule

`default_nettype wire
